// ----- src/nfha_pkg.sv -----
package nfha_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// heap layout constants (bytes and tag values)
	localparam int unsigned PROLOGUE_PAYLOAD = 8;
	localparam int unsigned FIRST_PAYLOAD    = 16;
	localparam int unsigned MIN_BLOCK        = 16;
	localparam int unsigned RESET_CHUNK      = 4096;
	localparam int unsigned TAG_ALLOC        = 1;
	localparam int unsigned PROLOGUE_TAG     = 9;

	localparam int unsigned CHUNK_W = 17;
	localparam int unsigned REQ_W   = 16;
	localparam int unsigned ADDR_W  = 16;

endpackage

// ----- src/nfha_if.sv -----
interface nfha_req_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [nfha_pkg::REQ_W-1:0]      request_bytes;
	logic [nfha_pkg::ADDR_W-1:0]     block_address;
	modport source (output valid, opcode, request_bytes, block_address, input ready);
	modport sink (input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface nfha_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      status;
	logic [nfha_pkg::ADDR_W-1:0]     payload_address;
	modport source (output valid, status, payload_address, input ready);
	modport sink (input valid, status, payload_address, output ready);
endinterface

interface nfha_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nfha_pkg::CHUNK_W-1:0]    grow_chunk_bytes;
	modport source (output valid, grow_chunk_bytes, input ready);
	modport sink (input valid, grow_chunk_bytes, output ready);
endinterface

// ----- src/next_fit_heap_allocator_unit.sv -----
// channel | dir | payload                               | accepted when
// cfg     | in  | grow_chunk_bytes                      | cfg.valid & cfg.ready
// req     | in  | opcode, request_bytes, block_address  | req.valid & req.ready
// rsp     | out | status, payload_address               | rsp.valid & rsp.ready
//
// One request at a time: a zero size goes straight to the response; an allocate walks
// headers from the rover, wraps once, grows the heap if needed (size check, 3 coalescing
// steps) and writes tags; a free walks blocks from the first block, then coalesces.
// The walk is set by the single read port of the heap memory.
// After reset, init writes the prologue, the first chunk if it fits, and the epilogue.
// A stalled response holds; the next request is taken once its word is loaded.
module next_fit_heap_allocator_unit #(
	parameter int unsigned HEAP_WORDS = 16384
) (
	input  logic          clk,
	input  logic          arst_n,
	nfha_cfg_if.sink      cfg,
	nfha_req_if.sink      req,
	nfha_rsp_if.source    rsp
);
	localparam int unsigned IW  = $clog2(HEAP_WORDS);
	localparam int unsigned AW  = IW + 3;
	localparam int unsigned XW  = (AW > 18) ? AW : 18;
	localparam int unsigned CAP = HEAP_WORDS * 4;
	localparam bit BIG = (CAP >= nfha_pkg::RESET_CHUNK + nfha_pkg::FIRST_PAYLOAD);

	typedef enum logic [15:0] {
		S_INIT  = 16'h0001,
		S_IDLE  = 16'h0002,
		S_S1A   = 16'h0004,
		S_S1B   = 16'h0008,
		S_P2S   = 16'h0010,
		S_P2A   = 16'h0020,
		S_P2B   = 16'h0040,
		S_GROW  = 16'h0080,
		S_MRGP  = 16'h0100,
		S_MRGN  = 16'h0200,
		S_MRGX  = 16'h0400,
		S_PLACE = 16'h0800,
		S_FTOP  = 16'h1000,
		S_FGOT  = 16'h2000,
		S_WRITE = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	state_t  state_q, after_q;

	logic [AW-1:0]  rover_q, heap_end_q, bp_q, fsize_q;
	logic [XW-1:0]  faddr_q;
	logic [XW-1:0]  asize_q;
	logic           op_free_q;
	logic [nfha_pkg::CHUNK_W-1:0] chunk_q;
	logic [31:0]    prev_tag_q;

	// pending tag writes
	logic [AW-1:0]  wa_q [4];
	logic [31:0]    wd_q [4];
	logic [1:0]     widx_q, wlast_q;
	logic [2:0]     init_q;

	// response register
	logic           rsp_valid_q;
	nfha_pkg::status_t res_status_q, rsp_status_q;
	logic [AW-1:0]  res_addr_q;
	logic [nfha_pkg::ADDR_W-1:0] rsp_addr_q;

	// memory port
	logic           mem_we;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [31:0]    mem_wdata, rdata;

	nfha_heap_mem #(.HEAP_WORDS(HEAP_WORDS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// decoded tag of the word read last cycle
	logic [AW-1:0] tag_s, bp_next;
	logic          tag_a, fits;
	assign tag_s   = {rdata[AW-1:3], 3'b000};
	assign tag_a   = rdata[0];
	assign bp_next = bp_q + tag_s;
	assign fits    = !tag_a && (XW'(tag_s) >= asize_q);

	logic req_acc;
	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// size for an allocate
	logic [XW-1:0] asize_in;
	always_comb begin
		if (req.request_bytes <= 16'd8) begin
			asize_in = XW'(nfha_pkg::MIN_BLOCK);
		end else begin
			asize_in = ((XW'(req.request_bytes) + XW'(15)) >> 3) << 3;
		end
	end

	// heap growth size and capacity check
	logic [XW-1:0] ext, gw;
	logic [XW:0]   gsz;
	logic          gfail;
	always_comb begin
		ext   = (asize_q > XW'(chunk_q)) ? asize_q : XW'(chunk_q);
		gw    = ext >> 2;
		gsz   = (XW+1)'(gw + XW'(gw[0])) << 2;
		gfail = (gsz == '0) || (gsz > ((XW+1)'(CAP) - (XW+1)'(heap_end_q)));
	end

	// coalesce computation
	logic [AW-1:0] nxt_s, prv_s, m_start, m_total;
	always_comb begin
		nxt_s   = tag_s;
		prv_s   = {prev_tag_q[AW-1:3], 3'b000};
		m_start = bp_q;
		m_total = fsize_q;
		if (!tag_a) begin
			m_total = m_total + nxt_s;
		end
		if (!prev_tag_q[0]) begin
			m_start = bp_q - prv_s;
			m_total = m_total + prv_s;
		end
	end

	// read address per step
	always_comb begin
		case (state_q)
			S_IDLE:              mem_raddr = rover_q - AW'(4);
			S_S1A:               mem_raddr = rover_q + tag_s - AW'(4);
			S_S1B, S_P2A, S_P2B: mem_raddr = bp_next - AW'(4);
			S_P2S:               mem_raddr = AW'(nfha_pkg::PROLOGUE_PAYLOAD - 4);
			S_MRGP:              mem_raddr = bp_q - AW'(8);
			S_MRGN:              mem_raddr = bp_q + fsize_q - AW'(4);
			default:             mem_raddr = bp_q - AW'(4);
		endcase
	end

	// reset-time layout writes
	logic [AW-1:0] init_a;
	logic [31:0]   init_d;
	logic          init_last;
	always_comb begin
		case (init_q)
			3'd0: begin
				init_a = AW'(4);
				init_d = 32'(nfha_pkg::PROLOGUE_TAG);
			end
			3'd1: begin
				init_a = AW'(8);
				init_d = 32'(nfha_pkg::PROLOGUE_TAG);
			end
			3'd2: begin
				init_a = AW'(12);
				init_d = BIG ? 32'(nfha_pkg::RESET_CHUNK) : 32'(nfha_pkg::TAG_ALLOC);
			end
			3'd3: begin
				init_a = AW'(nfha_pkg::FIRST_PAYLOAD + nfha_pkg::RESET_CHUNK - 8);
				init_d = 32'(nfha_pkg::RESET_CHUNK);
			end
			default: begin
				init_a = AW'(nfha_pkg::FIRST_PAYLOAD + nfha_pkg::RESET_CHUNK - 4);
				init_d = 32'(nfha_pkg::TAG_ALLOC);
			end
		endcase
		init_last = BIG ? (init_q == 3'd4) : (init_q == 3'd2);
	end

	always_comb begin
		mem_we    = (state_q == S_WRITE) || (state_q == S_INIT);
		mem_waddr = (state_q == S_INIT) ? init_a : wa_q[widx_q];
		mem_wdata = (state_q == S_INIT) ? init_d : wd_q[widx_q];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= nfha_pkg::CHUNK_W'(nfha_pkg::RESET_CHUNK);
		end else if (cfg.valid && cfg.ready) begin
			chunk_q <= cfg.grow_chunk_bytes;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			after_q    <= S_IDLE;
			init_q     <= '0;
			widx_q     <= '0;
			wlast_q    <= '0;
			rover_q    <= BIG ? AW'(nfha_pkg::FIRST_PAYLOAD) : AW'(nfha_pkg::PROLOGUE_PAYLOAD);
			heap_end_q <= BIG ? AW'(nfha_pkg::FIRST_PAYLOAD + nfha_pkg::RESET_CHUNK)
			                  : AW'(nfha_pkg::FIRST_PAYLOAD);
			rsp_valid_q <= 1'b0;
		end else begin
			// word taken; a load in the final step sets valid itself
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 3'd1;
					if (init_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						op_free_q    <= req.opcode;
						asize_q      <= asize_in;
						faddr_q      <= XW'(req.block_address);
						res_status_q <= nfha_pkg::ST_OK;
						res_addr_q   <= '0;
						bp_q         <= AW'(nfha_pkg::FIRST_PAYLOAD);
						if (req.opcode) begin
							state_q <= S_FTOP;
						end else if (req.request_bytes == '0) begin
							res_status_q <= nfha_pkg::ST_ZERO;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_S1A;
						end
					end
				end
				S_S1A: begin
					bp_q    <= rover_q + tag_s;
					state_q <= S_S1B;
				end
				S_S1B: begin
					if (tag_s == '0) begin
						state_q <= S_P2S;
					end else if (fits) begin
						rover_q <= bp_q;
						fsize_q <= tag_s;
						state_q <= S_PLACE;
					end else begin
						bp_q <= bp_next;
					end
				end
				S_P2S: begin
					bp_q <= AW'(nfha_pkg::PROLOGUE_PAYLOAD);
					if (AW'(nfha_pkg::PROLOGUE_PAYLOAD) < rover_q) begin
						state_q <= S_P2A;
					end else begin
						state_q <= S_GROW;
					end
				end
				S_P2A: begin
					if (tag_s == '0) begin
						state_q <= S_GROW;
					end else begin
						bp_q    <= bp_next;
						state_q <= S_P2B;
					end
				end
				S_P2B: begin
					if (fits) begin
						rover_q <= bp_q;
						fsize_q <= tag_s;
						state_q <= S_PLACE;
					end else if (!(bp_q < rover_q) || (tag_s == '0)) begin
						state_q <= S_GROW;
					end else begin
						bp_q <= bp_next;
					end
				end
				S_GROW: begin
					if (gfail) begin
						res_status_q <= nfha_pkg::ST_FULL;
						state_q      <= S_FIN;
					end else begin
						wa_q[0]    <= heap_end_q - AW'(4);
						wd_q[0]    <= 32'(gsz);
						wa_q[1]    <= heap_end_q + AW'(gsz) - AW'(8);
						wd_q[1]    <= 32'(gsz);
						wa_q[2]    <= heap_end_q + AW'(gsz) - AW'(4);
						wd_q[2]    <= 32'(nfha_pkg::TAG_ALLOC);
						wlast_q    <= 2'd2;
						widx_q     <= '0;
						bp_q       <= heap_end_q;
						fsize_q    <= AW'(gsz);
						heap_end_q <= heap_end_q + AW'(gsz);
						after_q    <= S_MRGP;
						state_q    <= S_WRITE;
					end
				end
				S_MRGP: begin
					state_q <= S_MRGN;
				end
				S_MRGN: begin
					prev_tag_q <= rdata;
					state_q    <= S_MRGX;
				end
				S_MRGX: begin
					rover_q <= m_start;
					bp_q    <= m_start;
					fsize_q <= m_total;
					wa_q[0] <= m_start - AW'(4);
					wd_q[0] <= 32'(m_total);
					wa_q[1] <= m_start + m_total - AW'(8);
					wd_q[1] <= 32'(m_total);
					wlast_q <= 2'd1;
					widx_q  <= '0;
					after_q <= op_free_q ? S_FIN : S_PLACE;
					if ((m_start != bp_q) || (m_total != fsize_q)) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= op_free_q ? S_FIN : S_PLACE;
					end
				end
				S_PLACE: begin
					widx_q     <= '0;
					rover_q    <= bp_q;
					res_addr_q <= bp_q;
					after_q    <= S_FIN;
					state_q    <= S_WRITE;
					if ((XW'(fsize_q) - asize_q) >= XW'(nfha_pkg::MIN_BLOCK)) begin
						wa_q[0] <= bp_q - AW'(4);
						wd_q[0] <= 32'(asize_q) | 32'(nfha_pkg::TAG_ALLOC);
						wa_q[1] <= bp_q + AW'(asize_q) - AW'(8);
						wd_q[1] <= 32'(asize_q) | 32'(nfha_pkg::TAG_ALLOC);
						wa_q[2] <= bp_q + AW'(asize_q) - AW'(4);
						wd_q[2] <= 32'(fsize_q - AW'(asize_q));
						wa_q[3] <= bp_q + fsize_q - AW'(8);
						wd_q[3] <= 32'(fsize_q - AW'(asize_q));
						wlast_q <= 2'd3;
					end else begin
						wa_q[0] <= bp_q - AW'(4);
						wd_q[0] <= 32'(fsize_q) | 32'(nfha_pkg::TAG_ALLOC);
						wa_q[1] <= bp_q + fsize_q - AW'(8);
						wd_q[1] <= 32'(fsize_q) | 32'(nfha_pkg::TAG_ALLOC);
						wlast_q <= 2'd1;
					end
				end
				S_FTOP: begin
					if ((bp_q < heap_end_q) && (XW'(bp_q) <= faddr_q)) begin
						state_q <= S_FGOT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FGOT: begin
					if (tag_s == '0) begin
						state_q <= S_FIN;
					end else if (XW'(bp_q) == faddr_q) begin
						if (tag_a) begin
							wa_q[0] <= bp_q - AW'(4);
							wd_q[0] <= 32'(tag_s);
							wa_q[1] <= bp_q + tag_s - AW'(8);
							wd_q[1] <= 32'(tag_s);
							wlast_q <= 2'd1;
							widx_q  <= '0;
							fsize_q <= tag_s;
							after_q <= S_MRGP;
							state_q <= S_WRITE;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						bp_q    <= bp_next;
						state_q <= S_FTOP;
					end
				end
				S_WRITE: begin
					widx_q <= widx_q + 2'd1;
					if (widx_q == wlast_q) begin
						state_q <= after_q;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_addr_q   <= nfha_pkg::ADDR_W'(res_addr_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.payload_address = rsp_addr_q;

	// checks
	a_end_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(heap_end_q[2:0] == 3'b000) && ((XW+1)'(heap_end_q) <= (XW+1)'(CAP)))
		else $error("heap end misaligned or past capacity");

	a_rover_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q[2:0] == 3'b000)
		else $error("rover misaligned");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_WRITE || state_q == S_INIT))
		else $error("heap write outside a write step");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !$rose(rsp.valid))
		else $error("response in the cycle after a request");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != nfha_pkg::ST_OK) |-> (rsp.payload_address == '0))
		else $error("failed allocate returned an address");
endmodule

// ----- src/nfha_heap_mem.sv -----
// heap word store: one write and one registered read per cycle
// words beyond the store read as an epilogue tag, writes there are dropped
module nfha_heap_mem #(
	parameter int unsigned HEAP_WORDS = 16384,
	parameter int unsigned AW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	localparam int unsigned IW = $clog2(HEAP_WORDS);

	logic [31:0]   mem [HEAP_WORDS];
	logic [AW-3:0] widx, ridx;
	logic          w_in, r_in;

	assign widx = waddr[AW-1:2];
	assign ridx = raddr[AW-1:2];
	assign w_in = widx < (AW-2)'(HEAP_WORDS);
	assign r_in = ridx < (AW-2)'(HEAP_WORDS);

	always_ff @(posedge clk) begin
		if (we && w_in) begin
			mem[widx[IW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (r_in) begin
			rdata <= mem[ridx[IW-1:0]];
		end else begin
			rdata <= 32'(nfha_pkg::TAG_ALLOC);
		end
	end
endmodule
